@@ sv/expiring_id_timer_table_macros.svh @@
// ----------------------------------------------------------------------------
// expiring_id_timer_table_macros.svh
// assertion macros shared by the timer table checker
// ----------------------------------------------------------------------------
`ifndef EXPIRING_ID_TIMER_TABLE_MACROS_SVH
`define EXPIRING_ID_TIMER_TABLE_MACROS_SVH

// same-cycle implication, disabled while rst_sig is high
`define EITT_ASSERT_NOW(label, clk_sig, rst_sig, lhs, rhs) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (lhs) |-> (rhs)) \
    else $error("eitt assertion failed");

// next-cycle implication, disabled while rst_sig is high
`define EITT_ASSERT_NEXT(label, clk_sig, rst_sig, lhs, rhs) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (lhs) |=> (rhs)) \
    else $error("eitt assertion failed");

`endif

@@ sv/eitt_pkg.sv @@
// ----------------------------------------------------------------------------
// eitt_pkg
// constants, types and helpers of the expiring id timer table
// ----------------------------------------------------------------------------
package eitt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int TOTAL_W     = 9;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 80;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CHECK  = 3'd1;
  localparam logic [2:0] OP_REMAIN = 3'd2;
  localparam logic [2:0] OP_TICK   = 3'd3;
  localparam logic [2:0] OP_TIME   = 3'd4;

  typedef struct packed {
    logic [31:0] ident;
    logic [31:0] expiry;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ sv/eitt_ram.sv @@
// ----------------------------------------------------------------------------
// eitt_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module eitt_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/expiring_id_timer_table.sv @@
// ----------------------------------------------------------------------------
// expiring_id_timer_table
// table of timed identifiers with a saturating time counter
// ----------------------------------------------------------------------------
// one command item enters on the s_ side (op in s_tuser, operands in s_tdata)
// and every command gives exactly one result item on the m_ side.
// add, check and remaining walk the live entries in a registered-read ram,
// one entry a cycle, and stop at the first match or at the end of the live entries.
// tick advances the counter at accept, then sweeps the table: each entry is
// read and checked; a removed entry other than the last is replaced by the
// last entry, written into the freed slot and then checked again.
// an add on a full table, read time and the unused ops go straight to the result.
// one command is in work at a time; s_tready is high only between commands.
// the result sits in an output register, so the next command is taken while
// the receiver stalls; a finished result waits until that register is free.
// reset empties the table and clears the counter at once: the count bounds
// every sweep, so the ram needs no clearing pass.
// ----------------------------------------------------------------------------
module expiring_id_timer_table
  import eitt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // ident[31:0], duration[55:32], tick_delta[71:56]
  input  logic [2:0]       s_tuser,   // op[2:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // absent, remaining, status, now_time, entry_total
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FIND = 6'b000010,
    S_TRD  = 6'b000100,
    S_TCHK = 6'b001000,
    S_TMV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state;
  logic [2:0]        op_q;
  logic [31:0]       id_q;
  logic [31:0]       exp_q;
  logic [CNT_W-1:0]  count;
  logic [31:0]       now;
  logic [CNT_W-1:0]  scan_idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  pend_idx;
  logic              res_absent;
  logic [31:0]       res_rem;
  logic              res_status;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            ram_rdata;

  logic [31:0]       in_ident;
  logic [23:0]       in_dur;
  logic [15:0]       in_dt;
  logic [31:0]       dur_scaled;
  logic              hit;
  logic              miss;
  logic              expired;
  logic [31:0]       rem_val;
  logic [CNT_W-1:0]  last_cnt;
  logic              full;
  logic              res_load;

  assign in_ident   = s_tdata[31:0];
  assign in_dur     = s_tdata[55:32];
  assign in_dt      = s_tdata[71:56];
  // times twenty as shifts: 16x + 4x
  assign dur_scaled = {4'd0, in_dur, 4'd0} + {6'd0, in_dur, 2'd0};

  assign s_tready = (state == S_IDLE);
  assign full     = (count >= CNT_W'(TABLE_DEPTH));
  assign last_cnt = count - CNT_W'(1);
  assign hit      = rd_pend && (ram_rdata.ident == id_q);
  assign miss     = !rd_pend && (scan_idx >= count);
  assign expired  = ram_rdata.expiry < now;
  assign rem_val  = (ram_rdata.expiry > now) ? (ram_rdata.expiry - now) : 32'd0;
  assign res_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_idx[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = scan_idx[IDX_W-1:0];
    unique case (state)
      S_FIND: begin
        if (op_q == OP_ADD && (hit || miss)) begin
          ram_we    = 1'b1;
          ram_waddr = hit ? pend_idx : count[IDX_W-1:0];
          ram_wdata = '{ident: id_q, expiry: exp_q};
        end
      end
      // fetch the last entry to fill the slot being freed
      S_TCHK:  ram_raddr = last_cnt[IDX_W-1:0];
      S_TMV:   ram_we = 1'b1;
      default: ;
    endcase
  end

  eitt_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      now      <= '0;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q       <= s_tuser;
            id_q       <= in_ident;
            exp_q      <= sat_add32(now, dur_scaled);
            scan_idx   <= '0;
            rd_pend    <= 1'b0;
            res_absent <= 1'b0;
            res_rem    <= '0;
            res_status <= 1'b0;
            unique case (s_tuser) inside
              OP_ADD: begin
                if (full) begin
                  res_status <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  state <= S_FIND;
                end
              end
              OP_CHECK, OP_REMAIN: state <= S_FIND;
              OP_TICK: begin
                now   <= sat_add32(now, {16'd0, in_dt});
                state <= S_TRD;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FIND: begin
          // reads run one entry ahead of the compare
          if (scan_idx < count) begin
            rd_pend  <= 1'b1;
            pend_idx <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            rd_pend <= 1'b0;
          end
          if (hit) begin
            if (op_q == OP_REMAIN) begin
              res_rem <= rem_val;
            end
            state <= S_DONE;
          end else if (miss) begin
            if (op_q == OP_ADD) begin
              count <= count + CNT_W'(1);
            end
            if (op_q == OP_CHECK) begin
              res_absent <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_TRD: begin
          state <= (scan_idx < count) ? S_TCHK : S_DONE;
        end
        S_TCHK: begin
          if (expired) begin
            count <= last_cnt;
            // dropping the last entry needs no move
            state <= (scan_idx == last_cnt) ? S_TRD : S_TMV;
          end else begin
            scan_idx <= scan_idx + CNT_W'(1);
            state    <= S_TRD;
          end
        end
        S_TMV: begin
          // moved entry is read back from the same slot and checked again
          state <= S_TRD;
        end
        S_DONE: begin
          if (res_load) begin
            m_tdata <= {5'd0, TOTAL_W'(count), now, res_status, res_rem, res_absent};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/eitt_checker.sv @@
// ----------------------------------------------------------------------------
// eitt_checker
// port-level assertions for the expiring id timer table, bound to the top
// ----------------------------------------------------------------------------
`include "expiring_id_timer_table_macros.svh"

module eitt_checker
  import eitt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic [2:0]       s_tuser,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [TOTAL_W-1:0] total;
  logic               inputs_seen;

  assign total       = m_tdata[74:66];
  assign inputs_seen = s_tvalid || (s_tdata != '0) || (s_tuser != '0);

  // no result item right after reset
  `EITT_ASSERT_NEXT(a_reset_quiet, clk, 1'b0, rst, !m_tvalid)
  // a stalled result holds
  `EITT_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // an add is refused only when the table is full
  `EITT_ASSERT_NOW(a_full_flag, clk, rst, m_tvalid && m_tdata[33],
                   total == TOTAL_W'(TABLE_DEPTH))
  // absent never comes with a nonzero remaining time or with the status flag
  `EITT_ASSERT_NOW(a_absent_rem, clk, rst, m_tvalid && m_tdata[0],
                   (m_tdata[32:1] == 32'd0) && !m_tdata[33])
  // a command is never taken in the cycle after one was taken
  `EITT_ASSERT_NEXT(a_one_cmd, clk, rst, s_tvalid && s_tready && inputs_seen, !s_tready)

endmodule

bind expiring_id_timer_table eitt_checker u_eitt_checker (.*);
